>>> hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, request codes, helper functions and the command struct
// that runs between the double-ended queue controller and its datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  // ring geometry
  localparam int unsigned DEPTH   = 16;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  // payload widths
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_FRONT   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_BACK    = 3'd5;

  typedef logic [ADDR_W-1:0] addr_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_req;  // capture the incoming transfer
    logic exec;      // update store, pointers and count
    logic load_out;  // fill the output register
  } deq_cmd_t;

  // wrap-around increment of a ring pointer
  function automatic addr_t ptr_inc(input addr_t p);
    addr_t r;
    if (p == addr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + addr_t'(1);
    end
    return r;
  endfunction

  // wrap-around decrement of a ring pointer
  function automatic addr_t ptr_dec(input addr_t p);
    addr_t r;
    if (p == '0) begin
      r = addr_t'(DEPTH - 1);
    end else begin
      r = p - addr_t'(1);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer of the double-ended queue: takes one transfer, lets the datapath
// execute it, then hands the result to the output register.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output deq_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // output register may be refilled when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.load_req = 1'b0;
    cmd_o.exec     = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, front and back pointers, entry count and output register of
// the double-ended queue.
// ----------------------------------------------------------------------------
module deq_datapath
  import deq_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  deq_cmd_t                        cmd_i,
  input  logic        [REQ_W-1:0]         req_type_i,
  input  logic signed [WORD_W-1:0]        value_i,
  output logic                            ok_o,
  output logic signed [WORD_W-1:0]        read_word_o,
  output logic        [ENTRY_COUNT_W-1:0] entry_count_o,
  output logic                            is_empty_o
);

  logic [WORD_W-1:0]  mem [DEPTH];

  logic [REQ_W-1:0]   req_q;
  logic [WORD_W-1:0]  val_q;
  addr_t              front_q, front_d;
  addr_t              back_q, back_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               ok_q, ok_d;
  logic               is_read_q, is_read_d;
  logic [WORD_W-1:0]  rd_data_q;

  logic               wr_en, rd_en;
  addr_t              wr_addr, rd_addr;
  logic               full, empty;

  logic               out_ok_q;
  logic [WORD_W-1:0]  out_word_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_empty_q;

  assign full  = (count_q == COUNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_type_i;
      val_q <= value_i;
    end
  end

  // request decode and state update
  always_comb begin
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    ok_d      = 1'b0;
    is_read_d = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = back_q;
    rd_en     = 1'b0;
    rd_addr   = front_q;
    case (req_q)
      REQ_PUSH_FRONT: begin
        if (!full) begin
          front_d = ptr_dec(front_q);
          wr_addr = ptr_dec(front_q);
          wr_en   = 1'b1;
          count_d = count_q + COUNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (!full) begin
          back_d  = ptr_inc(back_q);
          wr_addr = back_q;
          wr_en   = 1'b1;
          count_d = count_q + COUNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      REQ_REMOVE_FRONT: begin
        if (!empty) begin
          front_d = ptr_inc(front_q);
          count_d = count_q - COUNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      REQ_REMOVE_BACK: begin
        if (!empty) begin
          back_d  = ptr_dec(back_q);
          count_d = count_q - COUNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      REQ_READ_FRONT: begin
        if (!empty) begin
          rd_en     = 1'b1;
          rd_addr   = front_q;
          is_read_d = 1'b1;
          ok_d      = 1'b1;
        end
      end
      REQ_READ_BACK: begin
        if (!empty) begin
          rd_en     = 1'b1;
          rd_addr   = ptr_dec(back_q);
          is_read_d = 1'b1;
          ok_d      = 1'b1;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // ring store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem[wr_addr] <= val_q;
    end
    if (cmd_i.exec && rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
    end
  end

  // per-request flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q      <= ok_d;
      is_read_q <= is_read_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_ok_q    <= ok_q;
      out_word_q  <= is_read_q ? rd_data_q : '0;
      out_count_q <= count_q;
      out_empty_q <= (count_q == '0);
    end
  end

  assign ok_o          = out_ok_q;
  assign read_word_o   = out_word_q;
  assign entry_count_o = ENTRY_COUNT_W'(out_count_q);
  assign is_empty_o    = out_empty_q;

endmodule

>>> hw/rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit words in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: req_type_i and value_i, transfer when in_valid_i is high
//   and in_stall_o is low. Requests push or remove at either end, or read
//   the front or back word without removing it.
//   Output channel: one result per request (ok_o, read_word_o,
//   entry_count_o, is_empty_o), transfer when out_valid_o is high and
//   out_stall_i is low.
//   Sequence: each request passes through capture, execute and write-back
//   into the output register, around the single store port; the next
//   request is taken only after write-back of the last.
//   The next request is taken while a result still waits in the output
//   register.
//   Stall: while out_stall_i holds a result, the following request finishes
//   execution and then waits, keeping in_stall_o high.
//   Reset: pointers and count clear, the queue is empty, no result pending.
//   The store contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic        [REQ_W-1:0]         req_type_i,
  input  logic signed [WORD_W-1:0]        value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            ok_o,
  output logic signed [WORD_W-1:0]        read_word_o,
  output logic        [ENTRY_COUNT_W-1:0] entry_count_o,
  output logic                            is_empty_o
);

  deq_cmd_t cmd;

  // sequencer
  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // store, pointers and result
  deq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .ok_o          (ok_o),
    .read_word_o   (read_word_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  // checks
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a request is in flight");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

  a_word_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (read_word_o != '0)) |-> ok_o)
    else $error("nonzero read word on a failed request");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(entry_count_o) <= 32'(DEPTH)))
    else $error("entry count above capacity");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks double_ended_queue_top against a predictor of the ring contents,
// the front and back indexes and the fill level. Directed requests cover the
// empty queue, unused codes and word extremes. Random bursts then fill,
// drain and mix requests, with sender and receiver idling in several phases.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  // request codes the block ignores
  localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

  localparam int PHASE_ITEMS = 290;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic                      ok;
    logic signed [WORD_W-1:0]  read_word;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic                      is_empty;
  } deq_result_t;

  typedef struct packed {
    logic [REQ_W-1:0]         kind;
    logic signed [WORD_W-1:0] word;
    logic                     typed;
    deq_result_t              res;
  } deq_step_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [REQ_W-1:0] req_type_i;
  logic signed [WORD_W-1:0] value_i;
  logic out_valid_o;
  logic out_stall_i;
  logic ok_o;
  logic signed [WORD_W-1:0] read_word_o;
  logic [ENTRY_COUNT_W-1:0] entry_count_o;
  logic is_empty_o;

  // predicted queue state
  logic [WORD_W-1:0]  ring_words [DEPTH];
  logic [ADDR_W-1:0]  head_idx;
  logic [ADDR_W-1:0]  tail_idx;
  logic [COUNT_W-1:0] fill_level;

  deq_result_t pending_results [$];
  deq_step_t   directed_steps [$];
  int          mismatch_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  always #10 clk_i = ~clk_i;

  double_ended_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .read_word_o   (read_word_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

  task automatic report_mismatch(input string what);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $time, what);
    end
    mismatch_cnt++;
  endtask

  // apply one request to the predicted ring and return its result
  function automatic deq_result_t ring_apply(input logic [REQ_W-1:0] kind,
                                             input logic [WORD_W-1:0] word);
    deq_result_t res;
    bit full;
    bit none;
    full = (fill_level == COUNT_W'(DEPTH));
    none = (fill_level == '0);
    res = '0;
    case (kind)
      REQ_PUSH_FRONT: begin
        if (!full) begin
          head_idx = (head_idx == '0) ? ADDR_W'(DEPTH - 1) : head_idx - 1'b1;
          ring_words[head_idx] = word;
          fill_level++;
          res.ok = 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (!full) begin
          ring_words[tail_idx] = word;
          tail_idx = (tail_idx == ADDR_W'(DEPTH - 1)) ? '0 : tail_idx + 1'b1;
          fill_level++;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE_FRONT: begin
        if (!none) begin
          head_idx = (head_idx == ADDR_W'(DEPTH - 1)) ? '0 : head_idx + 1'b1;
          fill_level--;
          res.ok = 1'b1;
        end
      end
      REQ_REMOVE_BACK: begin
        if (!none) begin
          tail_idx = (tail_idx == '0) ? ADDR_W'(DEPTH - 1) : tail_idx - 1'b1;
          fill_level--;
          res.ok = 1'b1;
        end
      end
      REQ_READ_FRONT: begin
        if (!none) begin
          res.read_word = ring_words[head_idx];
          res.ok = 1'b1;
        end
      end
      REQ_READ_BACK: begin
        if (!none) begin
          res.read_word =
            ring_words[(tail_idx == '0) ? ADDR_W'(DEPTH - 1) : tail_idx - 1'b1];
          res.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = ENTRY_COUNT_W'(fill_level);
    res.is_empty = (fill_level == '0);
    return res;
  endfunction

  task automatic add_step(input logic [REQ_W-1:0] kind,
                          input logic signed [WORD_W-1:0] word,
                          input logic typed, input deq_result_t res);
    directed_steps.push_back('{kind, word, typed, res});
  endtask

  // drive one request and record its expected result once it transfers
  task automatic issue_request(input logic [REQ_W-1:0] kind,
                               input logic signed [WORD_W-1:0] word,
                               input logic typed, input deq_result_t typed_res);
    deq_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    value_i    <= word;
    do @(posedge clk_i); while (in_stall_o);
    predicted = ring_apply(kind, word);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // result side: check each transfer and stall at random
  initial begin : result_monitor
    deq_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = pending_results.pop_front();
          if (ok_o !== want.ok)
            report_mismatch($sformatf("ok %0b, expected %0b", ok_o, want.ok));
          if (read_word_o !== want.read_word)
            report_mismatch($sformatf("read_word %0d, expected %0d",
                                      read_word_o, want.read_word));
          if (entry_count_o !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      entry_count_o, want.entry_count));
          if (is_empty_o !== want.is_empty)
            report_mismatch($sformatf("is_empty %0b, expected %0b",
                                      is_empty_o, want.is_empty));
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // request side: directed table, then random bursts per idling phase
  initial begin : request_driver
    int phase_idle [4];
    int phase_stall [4];
    int push_cut [3];
    int remove_cut [3];
    int sent;
    int seg_mode;
    int seg_len;
    int pick;
    logic [REQ_W-1:0] kind;
    logic signed [WORD_W-1:0] word;
    deq_step_t step;

    phase_idle  = '{0, 68, 0, 29};
    phase_stall = '{0, 0, 68, 29};
    // fill, drain and mixed bursts
    push_cut    = '{80, 15, 40};
    remove_cut  = '{90, 85, 70};

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_PUSH_FRONT;
    value_i     <= '0;
    out_stall_i <= 1'b0;
    head_idx    = '0;
    tail_idx    = '0;
    fill_level  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ring_words[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, unused codes and word extremes
    add_step(REQ_READ_FRONT,   32'sd0, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1});
    add_step(REQ_READ_BACK,    32'sd0, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1});
    add_step(REQ_REMOVE_FRONT, 32'sd0, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1});
    add_step(REQ_REMOVE_BACK,  32'sd0, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1});
    add_step(REQ_UNUSED_6,     32'sd0, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1});
    add_step(REQ_UNUSED_7,     -32'sd1, 1'b1, '{1'b0, 32'sd0, 5'd0, 1'b1});
    add_step(REQ_PUSH_FRONT, 32'sh7FFFFFFF, 1'b1, '{1'b1, 32'sd0, 5'd1, 1'b0});
    add_step(REQ_PUSH_BACK,  32'sh80000000, 1'b1, '{1'b1, 32'sd0, 5'd2, 1'b0});
    add_step(REQ_READ_FRONT, 32'sd0, 1'b1, '{1'b1, 32'sh7FFFFFFF, 5'd2, 1'b0});
    add_step(REQ_READ_BACK,  32'sd0, 1'b1, '{1'b1, 32'sh80000000, 5'd2, 1'b0});
    add_step(REQ_PUSH_FRONT, 32'sd0, 1'b0, '0);
    add_step(REQ_PUSH_BACK,  -32'sd1, 1'b0, '0);
    add_step(REQ_READ_FRONT, 32'sd0, 1'b0, '0);
    add_step(REQ_READ_BACK,  32'sd0, 1'b0, '0);
    add_step(REQ_UNUSED_6,   32'sh55555555, 1'b0, '0);
    add_step(REQ_REMOVE_FRONT, 32'sd0, 1'b0, '0);
    add_step(REQ_REMOVE_BACK,  32'sd0, 1'b0, '0);
    add_step(REQ_READ_FRONT,   32'sd0, 1'b0, '0);
    add_step(REQ_READ_BACK,    32'sd0, 1'b0, '0);
    add_step(REQ_REMOVE_FRONT, 32'sd0, 1'b0, '0);
    add_step(REQ_REMOVE_BACK,  32'sd0, 1'b0, '0);
    add_step(REQ_REMOVE_FRONT, 32'sd0, 1'b0, '0);
    add_step(REQ_PUSH_BACK,  32'sh55555555, 1'b0, '0);
    add_step(REQ_PUSH_FRONT, 32'shAAAAAAAA, 1'b0, '0);
    add_step(REQ_READ_BACK,  32'sd0, 1'b0, '0);

    foreach (directed_steps[i]) begin
      step = directed_steps[i];
      issue_request(step.kind, step.word, step.typed, step.res);
    end

    // random bursts; fill bursts push the queue toward its full state
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        seg_mode = $urandom_range(2);
        seg_len  = $urandom_range(40, 8);
        repeat (seg_len) begin
          pick = $urandom_range(99);
          if (pick < 3) begin
            kind = $urandom_range(1) ? REQ_UNUSED_6 : REQ_UNUSED_7;
          end else if (pick < push_cut[seg_mode]) begin
            kind = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
          end else if (pick < remove_cut[seg_mode]) begin
            kind = $urandom_range(1) ? REQ_REMOVE_FRONT : REQ_REMOVE_BACK;
          end else begin
            kind = $urandom_range(1) ? REQ_READ_FRONT : REQ_READ_BACK;
          end
          // occasional extreme words
          if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
              0: word = 32'sh7FFFFFFF;
              1: word = 32'sh80000000;
              2: word = 32'sd0;
              default: word = -32'sd1;
            endcase
          end else begin
            word = $urandom;
          end
          issue_request(kind, word, 1'b0, '0);
          if (kind != REQ_UNUSED_6 && kind != REQ_UNUSED_7) begin
            sent++;
          end
        end
      end
    end
    in_valid_i <= 1'b0;

    // let outstanding results drain
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // overall time limit
  initial begin : run_limit
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_ctrl.sv
hw/rtl/deq_datapath.sv
hw/rtl/double_ended_queue_top.sv
test/testbench.sv
